// File: hdl/pits_pkg.sv
// Shared types and constants for the priority inheritance tick scheduler.
// Used by the channel interfaces, the controller, the datapath and the top level.
package pits_pkg;

    localparam int MAX_JOBS = 8;
    localparam int SLOT_W   = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;

    // kind codes of an input item
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [2:0]  slot;
        logic [7:0]  job_id;
        logic [3:0]  resource;
        logic [31:0] release_time;
        logic [15:0] run_length;
        logic [7:0]  priority_req;
    } item_t;

    typedef struct packed {
        logic       idle;
        logic [7:0] run_id;
        logic [7:0] run_level;
        logic       finished;
    } result_t;

    // one job table row
    typedef struct packed {
        logic [7:0]  id;
        logic [3:0]  resource;
        logic [31:0] release_time;
        logic [15:0] remaining;
        logic [7:0]  level;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic              load;
        logic              rd_en;
        logic [SLOT_W-1:0] rd_slot;
        logic              eval;
        logic              finish;
    } cmd_t;

    typedef struct packed {
        logic out_busy;
    } status_t;

endpackage

// File: hdl/pits_in_if.sv
// Input channel of the scheduler: valid/ready handshake carrying one item_t.
// Depends on pits_pkg.
interface pits_in_if;
    import pits_pkg::*;

    logic  valid;
    logic  ready;
    item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/pits_out_if.sv
// Result channel of the scheduler: valid/ready handshake carrying one result_t.
// Depends on pits_pkg.
interface pits_out_if;
    import pits_pkg::*;

    logic    valid;
    logic    ready;
    result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/priority_inherit_tick_scheduler.sv
// A load item is accepted in S_IDLE and writes its job into the table unless its
// run length is zero. A tick item passes S_IDLE to accept it, S_SCAN to read
// each slot of the job table through its single read port, S_LAST to evaluate
// the last row, and S_FINISH to charge the runner and place the result in the
// output register. The next item is accepted as soon as that result is
// registered, even while it still waits for its transfer; a tick whose result
// finds the output register still full waits in S_FINISH.
// Depends on pits_pkg, pits_in_if, pits_out_if, pits_ram, pits_ctrl, pits_dp.
module priority_inherit_tick_scheduler (
    input  logic       clk,
    input  logic       rst_n,
    pits_in_if.sink    request,
    pits_out_if.source result
);
    import pits_pkg::*;

    cmd_t    cmd;
    status_t status;

    pits_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (request.valid),
        .req_kind  (request.data.kind),
        .req_ready (request.ready),
        .cmd       (cmd),
        .status    (status)
    );

    pits_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (request.data),
        .cmd       (cmd),
        .status    (status),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .out_data  (result.data)
    );
endmodule

// File: hdl/pits_ram.sv
// Generic single write port, single read port RAM with registered read data.
// Stand-alone; no package dependency.
module pits_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end
endmodule

// File: hdl/pits_ctrl.sv
// Sequencer of the scheduler: takes items, walks the job table for a tick and
// raises the result step. Depends on pits_pkg; drives pits_dp through cmd_t.
module pits_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic              req_kind,
    output logic              req_ready,
    output pits_pkg::cmd_t    cmd,
    input  pits_pkg::status_t status
);
    import pits_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_LAST,
        S_FINISH
    } state_t;

    state_t            state_reg, state_next;
    logic [SLOT_W-1:0] idx_reg, idx_next;
    logic              last_idx;

    assign last_idx = (idx_reg == SLOT_W'(MAX_JOBS - 1));

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        req_ready   = 1'b0;
        cmd         = '0;
        cmd.rd_slot = idx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    if (req_kind == KIND_TICK)
                    begin
                        state_next = S_SCAN;
                        idx_next   = '0;
                    end
                    else
                    begin
                        cmd.load = 1'b1;
                    end
                end
            end
            S_SCAN:
            begin
                // read this slot while the previous one is evaluated
                cmd.rd_en = 1'b1;
                cmd.eval  = (idx_reg != '0);
                if (last_idx)
                begin
                    state_next = S_LAST;
                end
                else
                begin
                    idx_next = idx_reg + SLOT_W'(1);
                end
            end
            S_LAST:
            begin
                cmd.eval   = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                // hold until the result register can take the transfer
                if (!status.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end
endmodule

// File: hdl/pits_dp.sv
// Datapath of the scheduler: job table RAM, valid bits, runner copy, tick
// counter and result register. Depends on pits_pkg and pits_ram.
module pits_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  pits_pkg::item_t     item,
    input  pits_pkg::cmd_t      cmd,
    output pits_pkg::status_t   status,
    output logic                out_valid,
    input  logic                out_ready,
    output pits_pkg::result_t   out_data
);
    import pits_pkg::*;

    logic [MAX_JOBS-1:0] valid_reg, valid_next;
    logic                run_present_reg, run_present_next;
    logic [SLOT_W-1:0]   run_slot_reg, run_slot_next;
    entry_t              run_entry_reg, run_entry_next;
    logic [31:0]         tick_reg, tick_next;
    logic [SLOT_W-1:0]   eval_slot_reg;
    logic                wb_valid_reg;
    logic [SLOT_W-1:0]   wb_slot_reg;
    entry_t              wb_data_reg;
    logic                out_valid_reg, out_valid_next;
    result_t             out_data_reg, out_data_next;

    logic              ld_ok;
    logic [SLOT_W-1:0] ld_addr;
    entry_t            ld_entry;
    logic              evict;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    entry_t            wr_data;
    logic [ENTRY_W-1:0] rd_data;
    entry_t            cand;
    logic              cand_ok;
    logic              done;

    assign ld_addr  = SLOT_W'(item.slot);
    assign ld_ok    = cmd.load && (item.run_length != '0) && (32'(item.slot) < MAX_JOBS);
    assign ld_entry = '{id: item.job_id, resource: item.resource,
                        release_time: item.release_time, remaining: item.run_length,
                        level: item.priority_req};

    assign wr_en   = ld_ok || evict;
    assign wr_addr = evict ? run_slot_reg : ld_addr;
    assign wr_data = evict ? run_entry_reg : ld_entry;

    pits_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_JOBS)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (cmd.rd_slot),
        .rd_data (rd_data)
    );

    // forward a row written in the cycle its read was taken
    assign cand = (wb_valid_reg && (wb_slot_reg == eval_slot_reg)) ? wb_data_reg
                                                                   : entry_t'(rd_data);

    assign cand_ok = cmd.eval && valid_reg[eval_slot_reg]
                     && (cand.release_time <= tick_reg)
                     && !(run_present_reg && (run_slot_reg == eval_slot_reg));

    assign evict = cand_ok && run_present_reg && (cand.level > run_entry_reg.level)
                   && !((cand.resource != '0) && (cand.resource == run_entry_reg.resource));

    assign done = (run_entry_reg.remaining <= 16'd1);

    always_comb
    begin
        valid_next       = valid_reg;
        run_present_next = run_present_reg;
        run_slot_next    = run_slot_reg;
        run_entry_next   = run_entry_reg;
        tick_next        = tick_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_data_next    = out_data_reg;

        if (ld_ok)
        begin
            valid_next[ld_addr] = 1'b1;
            if (run_present_reg && (run_slot_reg == ld_addr))
            begin
                run_present_next = 1'b0;
            end
        end

        if (cand_ok)
        begin
            if (!run_present_reg || evict)
            begin
                run_present_next = 1'b1;
                run_slot_next    = eval_slot_reg;
                run_entry_next   = cand;
            end
            else if (cand.level > run_entry_reg.level)
            begin
                // shared resource: runner keeps the slot and inherits the level
                run_entry_next.level = cand.level;
            end
        end

        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
            if (run_present_reg)
            begin
                run_entry_next.remaining = done ? 16'd0 : run_entry_reg.remaining - 16'd1;
                out_data_next = '{idle: 1'b0, run_id: run_entry_reg.id,
                                  run_level: run_entry_reg.level, finished: done};
                if (done)
                begin
                    valid_next[run_slot_reg] = 1'b0;
                    run_present_next         = 1'b0;
                end
            end
            else
            begin
                out_data_next = '{idle: 1'b1, run_id: 8'd0, run_level: 8'd0,
                                  finished: 1'b0};
            end
            if (tick_reg != 32'hFFFF_FFFF)
            begin
                tick_next = tick_reg + 32'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg       <= '0;
            run_present_reg <= 1'b0;
            run_slot_reg    <= '0;
            tick_reg        <= '0;
            wb_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            valid_reg       <= valid_next;
            run_present_reg <= run_present_next;
            run_slot_reg    <= run_slot_next;
            tick_reg        <= tick_next;
            wb_valid_reg    <= evict;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        run_entry_reg <= run_entry_next;
        out_data_reg  <= out_data_next;
        wb_slot_reg   <= run_slot_reg;
        wb_data_reg   <= run_entry_reg;
        if (cmd.rd_en)
        begin
            eval_slot_reg <= cmd.rd_slot;
        end
    end

    assign status.out_busy = out_valid_reg && !out_ready;
    assign out_valid       = out_valid_reg;
    assign out_data        = out_data_reg;
endmodule

// File: test/priority_inherit_tick_scheduler_test.sv
// Self-checking testbench for priority_inherit_tick_scheduler: drives load and tick items,
// predicts each tick's runner with its own job table, and checks every result transfer.
// Depends on pits_pkg, pits_in_if, pits_out_if and the scheduler RTL.
module priority_inherit_tick_scheduler_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pits_pkg::*;

    localparam int TOTAL_ITEMS = 1900;
    localparam int CALM_FROM   = 1700;
    localparam int STALL_LIMIT = 1000;

    // Job table mirror and the queue of runs still owed by the block.
    class schedule_board;
        entry_t      jobs [MAX_JOBS];
        bit          live [MAX_JOBS];
        bit          busy;
        int          cur;
        bit [31:0]   now;
        result_t     due_runs [$];
        int          errors;
        int          checked;

        task flag(string msg);
            $display("ERROR at %0t: run %0d: %s", $time, checked, msg);
            errors++;
        endtask

        function int pending();
            return due_runs.size();
        endfunction

        function void note_item(item_t it);
            result_t outcome;
            int      s;
            if (it.kind == KIND_LOAD)
            begin
                s = int'(it.slot);
                if (it.run_length == 16'd0 || s >= MAX_JOBS)
                    return;
                live[s]              = 1'b1;
                jobs[s].id           = it.job_id;
                jobs[s].resource     = it.resource;
                jobs[s].release_time = it.release_time;
                jobs[s].remaining    = it.run_length;
                jobs[s].level        = it.priority_req;
                // overwriting the runner's slot leaves nothing running
                if (busy && cur == s)
                    busy = 1'b0;
                return;
            end
            for (int i = 0; i < MAX_JOBS; i++)
            begin
                if (!live[i] || jobs[i].release_time > now)
                    continue;
                if (busy && i == cur)
                    continue;
                if (!busy)
                begin
                    busy = 1'b1;
                    cur  = i;
                end
                else if (jobs[i].level > jobs[cur].level)
                begin
                    // sharing a resource: the holder keeps running at the higher level
                    if (jobs[i].resource != 4'd0 && jobs[i].resource == jobs[cur].resource)
                        jobs[cur].level = jobs[i].level;
                    else
                        cur = i;
                end
            end
            outcome = '0;
            if (busy)
            begin
                outcome.run_id    = jobs[cur].id;
                outcome.run_level = jobs[cur].level;
                if (jobs[cur].remaining <= 16'd1)
                begin
                    jobs[cur].remaining = 16'd0;
                    outcome.finished    = 1'b1;
                    live[cur]           = 1'b0;
                    busy                = 1'b0;
                end
                else
                    jobs[cur].remaining = jobs[cur].remaining - 16'd1;
            end
            else
                outcome.idle = 1'b1;
            due_runs.push_back(outcome);
            if (now != 32'hFFFF_FFFF)
                now++;
        endfunction

        task check_run(result_t got);
            result_t want;
            if (due_runs.size() == 0)
            begin
                flag("result transfer with no tick outstanding");
                return;
            end
            want = due_runs.pop_front();
            if (got.idle !== want.idle)
                flag($sformatf("idle %0b, expected %0b", got.idle, want.idle));
            if (got.run_id !== want.run_id)
                flag($sformatf("run_id %0h, expected %0h", got.run_id, want.run_id));
            if (got.run_level !== want.run_level)
                flag($sformatf("run_level %0h, expected %0h", got.run_level, want.run_level));
            if (got.finished !== want.finished)
                flag($sformatf("finished %0b, expected %0b", got.finished, want.finished));
            checked++;
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;
    bit   calm;
    int   stall_left;
    int   quiet;
    int unsigned ticks_sent;
    schedule_board board;

    pits_in_if  req_ch ();
    pits_out_if res_ch ();

    priority_inherit_tick_scheduler dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (req_ch),
        .result  (res_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result side: random stall bursts, none once the run has gone calm.
    always @(posedge clk)
    begin
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else if (calm)
            res_ch.ready <= 1'b1;
        else if (stall_left > 0)
        begin
            res_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            res_ch.ready <= 1'b0;
            stall_left   <= $urandom_range(0, 8);
        end
        else
            res_ch.ready <= 1'b1;
    end

    // Signals only move just after a rising edge, so the negedge sees what the next edge takes.
    always @(negedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
            board.check_run(res_ch.data);
    end

    always @(negedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= STALL_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Call at a rising edge; returns at the edge where the transfer happens.
    task send_item(item_t it);
        req_ch.valid <= 1'b1;
        req_ch.data  <= it;
        @(negedge clk);
        while (!req_ch.ready)
            @(negedge clk);
        @(posedge clk);
        board.note_item(it);
        if (it.kind == KIND_TICK)
            ticks_sent++;
    endtask

    task rest(int cycles);
        req_ch.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task drain_runs();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    task tick_once();
        item_t it;
        it      = '0;
        it.kind = KIND_TICK;
        it.slot = 3'($urandom);
        send_item(it);
    endtask

    task load_job(int slot, int id, int res, logic [31:0] rel, int len, int lvl);
        item_t it;
        it              = '0;
        it.kind         = KIND_LOAD;
        it.slot         = 3'(slot);
        it.job_id       = 8'(id);
        it.resource     = 4'(res);
        it.release_time = rel;
        it.run_length   = 16'(len);
        it.priority_req = 8'(lvl);
        send_item(it);
    endtask

    function automatic item_t random_item(int unsigned at_tick);
        item_t it;
        int    pick;
        it      = '0;
        it.kind = ($urandom_range(0, 99) < 45) ? KIND_LOAD : KIND_TICK;
        it.slot = 3'($urandom);
        it.job_id = 8'($urandom);
        it.resource = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(0, 2)) : 4'($urandom);
        pick = $urandom_range(0, 9);
        if (pick == 0)
            it.release_time = '0;
        else if (pick == 1)
            it.release_time = $urandom;
        else
            it.release_time = at_tick + $urandom_range(0, 5);
        pick = $urandom_range(0, 19);
        if (pick == 0)
            it.run_length = '0;
        else if (pick < 4)
            it.run_length = 16'($urandom);
        else
            it.run_length = 16'($urandom_range(1, 6));
        it.priority_req = $urandom_range(0, 1) ? 8'($urandom_range(0, 7)) : 8'($urandom);
        return it;
    endfunction

    initial
    begin
        rst_n        = 1'b0;
        calm         = 1'b0;
        stall_left   = 0;
        quiet        = 0;
        ticks_sent   = 0;
        board        = new();
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        res_ch.ready = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, zero length, unreleased job, inheritance, preemption
        tick_once();
        load_job(0, 8'h10, 1, 0, 0, 9);
        tick_once();
        load_job(7, 8'hFF, 15, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF);
        tick_once();
        load_job(0, 8'h00, 0, 0, 2, 0);
        tick_once();
        tick_once();
        load_job(1, 8'h11, 5, 0, 3, 10);
        tick_once();
        load_job(2, 8'h22, 5, 0, 2, 200);
        tick_once();
        // overwrite the running slot
        load_job(1, 8'h44, 6, 0, 1, 1);
        tick_once();
        load_job(3, 8'h33, 0, 0, 1, 250);
        tick_once();
        tick_once();
        tick_once();
        tick_once();
        load_job(6, 8'h66, 0, 0, 16'hFFFF, 0);
        tick_once();
        load_job(6, 8'h77, 0, 0, 1, 0);
        tick_once();
        load_job(7, 8'h5A, 0, 0, 1, 128);
        tick_once();
        drain_runs();

        for (int n = 0; n < TOTAL_ITEMS; n++)
        begin
            if (n == CALM_FROM)
                calm = 1'b1;
            if (n % 450 == 449)
                drain_runs();
            if (!calm && $urandom_range(0, 5) == 0)
                rest($urandom_range(1, 9));
            send_item(random_item(ticks_sent));
        end

        drain_runs();
        repeat (20) @(posedge clk);
        if (board.pending() != 0)
            board.flag($sformatf("%0d tick results never arrived", board.pending()));
        if (board.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
